>>> sv/scsc_pkg.sv
// Shared types and constants for the strategy cycle sign classifier.
`default_nettype none

package scsc_pkg;

    // Command codes of an input request
    localparam logic [1:0] CMD_LOAD_WEIGHT = 2'd0;
    localparam logic [1:0] CMD_LOAD_EDGE   = 2'd1;
    localparam logic [1:0] CMD_SOLVE       = 2'd2;
    localparam logic [1:0] CMD_QUERY       = 2'd3;

    // Visit marks kept per node during a solve
    localparam int         MARK_BITS = 2;
    localparam logic [1:0] MARK_NONE = 2'd0;
    localparam logic [1:0] MARK_PATH = 2'd1;
    localparam logic [1:0] MARK_DONE = 2'd2;

    // Saturated score range
    localparam int SCORE_BITS = 22;
    localparam int SCORE_MAX  = 2097151;
    localparam int SCORE_MIN  = -2097152;
    localparam logic signed [SCORE_BITS-1:0] SCORE_HI = 22'sh1FFFFF;
    localparam logic signed [SCORE_BITS-1:0] SCORE_LO = 22'sh200000;

    // Sequencer states
    typedef enum logic [4:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_LOAD_W,
        ST_EDGE_RD,
        ST_EDGE_WR,
        ST_QRY_RD,
        ST_QRY_OUT,
        ST_VCLR,
        ST_START_RD,
        ST_START_CHK,
        ST_MARK,
        ST_NEXT,
        ST_CHECK,
        ST_CYC_RD,
        ST_CYC_ACC,
        ST_SAT,
        ST_SC_RD,
        ST_SC_GET,
        ST_PROP_RD,
        ST_PROP_WR
    } t_state;

endpackage

`default_nettype wire

>>> sv/scsc_ram.sv
// Generic simple dual-port RAM with one write port and one registered read port.
`default_nettype none

module scsc_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64,
    localparam int AW   = $clog2(DEPTH)
) (
    input  wire logic             i_clk,
    input  wire logic             i_we,
    input  wire logic [AW-1:0]    i_waddr,
    input  wire logic [WIDTH-1:0] i_wdata,
    input  wire logic [AW-1:0]    i_raddr,
    output logic      [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write port and registered read
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

>>> sv/strategy_cycle_sign_classifier.sv
// Top level: functional-graph cycle scoring with a sequenced memory walk.
// Load weight: writes the weight and clears the node's edge; load edge: read, compare, write.
// Query: read, then the result register loads once free; a new request is taken while the result waits.
// Solve: accept, clear the marks of all n nodes, read and check each start node, mark, step and check
// each node walked, read and sum each cycle node, saturate or fetch the score per path, store each path entry.
// Reset: synchronous; a pass over all MAX_NODES entries clears scores and edge flags, ready stays low.
`default_nettype none

module strategy_cycle_sign_classifier #(
    parameter int MAX_NODES   = 64,
    parameter int FLOW_BITS   = 32,
    parameter int WEIGHT_BITS = 16,
    localparam int NW = $clog2(MAX_NODES),
    localparam int CW = $clog2(MAX_NODES + 1)
) (
    input  wire logic                   i_clk,
    input  wire logic                   i_rst_n,
    // configuration write channel
    input  wire logic                   i_cfg_valid,
    output logic                        o_cfg_ready,
    input  wire logic [CW-1:0]          i_cfg_data,
    // request channel
    input  wire logic                   i_valid,
    output logic                        o_ready,
    input  wire logic [1:0]             i_command,
    input  wire logic [NW-1:0]          i_node,
    input  wire logic [NW-1:0]          i_edge_target,
    input  wire logic signed [FLOW_BITS-1:0]   i_edge_flow,
    input  wire logic signed [WEIGHT_BITS-1:0] i_node_weight,
    // result channel
    output logic                        o_valid,
    input  wire logic                   i_ready,
    output logic [NW-1:0]               o_queried_node,
    output logic [NW-1:0]               o_successor,
    output logic signed [scsc_pkg::SCORE_BITS-1:0] o_cycle_score,
    output logic                        o_max_wins
);

    import scsc_pkg::*;

    localparam int PA_W = $clog2(MAX_NODES + 1);
    localparam int PL_W = $clog2(MAX_NODES + 2);
    localparam int EW   = 1 + NW + FLOW_BITS;
    localparam int SB   = SCORE_BITS;
    localparam int AW   = (WEIGHT_BITS + NW + 1 > SB + 1) ? (WEIGHT_BITS + NW + 1) : (SB + 1);
    localparam logic signed [AW-1:0] ACC_HI = AW'(SCORE_MAX);
    localparam logic signed [AW-1:0] ACC_LO = AW'(SCORE_MIN);

    // Control registers
    t_state          r_state, n_state;
    logic [CW-1:0]   r_node_count;
    logic [CW-1:0]   r_idx, n_idx;
    logic [NW-1:0]   r_start, n_start;
    logic [PL_W-1:0] r_plen, n_plen;
    logic [PL_W-1:0] r_k, n_k;
    logic            r_out_valid, n_out_valid;

    // Payload registers
    logic [NW-1:0]                   r_node, n_node;
    logic [NW-1:0]                   r_target, n_target;
    logic signed [FLOW_BITS-1:0]     r_flow, n_flow;
    logic signed [WEIGHT_BITS-1:0]   r_weight, n_weight;
    logic [NW-1:0]                   r_top, n_top;
    logic [NW-1:0]                   r_x, n_x;
    logic signed [AW-1:0]            r_acc, n_acc;
    logic signed [SB-1:0]            r_score, n_score;
    logic [NW-1:0]                   r_out_node, n_out_node;
    logic [NW-1:0]                   r_out_succ, n_out_succ;
    logic signed [SB-1:0]            r_out_score, n_out_score;
    logic                            r_out_max, n_out_max;

    // Memory ports
    logic                    w_wt_we;
    logic [NW-1:0]           w_wt_waddr, w_wt_raddr;
    logic [WEIGHT_BITS-1:0]  w_wt_wdata, w_wt_rd;
    logic                    w_ed_we;
    logic [NW-1:0]           w_ed_waddr, w_ed_raddr;
    logic [EW-1:0]           w_ed_wdata, w_ed_rd;
    logic                    w_sc_we;
    logic [NW-1:0]           w_sc_waddr, w_sc_raddr;
    logic [SB-1:0]           w_sc_wdata, w_sc_rd;
    logic                    w_vi_we;
    logic [NW-1:0]           w_vi_waddr, w_vi_raddr;
    logic [MARK_BITS-1:0]    w_vi_wdata, w_vi_rd;
    logic                    w_pa_we;
    logic [PA_W-1:0]         w_pa_waddr, w_pa_raddr;
    logic [NW-1:0]           w_pa_wdata, w_pa_rd;

    // Derived signals
    logic [CW-1:0]   w_n;
    logic            w_node_ok;
    logic            w_last_start;
    logic            w_prop_done;
    logic            w_out_free;
    logic            w_edge_take;
    logic [NW-1:0]   w_nxt_top;
    logic [NW-1:0]   w_nxt_x;
    logic [NW-1:0]   w_qry_succ;
    logic signed [AW-1:0] w_wt_ext;

    // Effective successor: self-loop without an edge or with an out-of-range target
    function automatic logic [NW-1:0] f_next(
        input logic [NW-1:0] v,
        input logic [EW-1:0] rec,
        input logic [CW-1:0] n
    );
        logic [NW-1:0] s;
        s = rec[FLOW_BITS +: NW];
        if (!rec[EW-1] || CW'(s) >= n) begin
            return v;
        end
        return s;
    endfunction

    // Clamp node count into the usable range
    always_comb begin
        if (r_node_count == '0) begin
            w_n = CW'(1);
        end else if (r_node_count > CW'(MAX_NODES)) begin
            w_n = CW'(MAX_NODES);
        end else begin
            w_n = r_node_count;
        end
    end

    assign w_node_ok    = CW'(r_node) < w_n;
    assign w_last_start = (CW'(r_start) + CW'(1)) == w_n;
    assign w_prop_done  = (r_k + PL_W'(1)) == r_plen;
    assign w_out_free   = !r_out_valid || i_ready;
    assign w_nxt_top    = f_next(r_top, w_ed_rd, w_n);
    assign w_nxt_x      = f_next(r_x, w_ed_rd, w_n);
    assign w_qry_succ   = f_next(r_node, w_ed_rd, w_n);
    assign w_wt_ext     = {{(AW - WEIGHT_BITS){w_wt_rd[WEIGHT_BITS-1]}}, w_wt_rd};
    assign w_edge_take  = w_node_ok && (!w_ed_rd[EW-1] ||
                          (r_flow > signed'(w_ed_rd[FLOW_BITS-1:0])));

    // Next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_CLEAR: begin
                if (r_idx == CW'(MAX_NODES - 1)) n_state = ST_IDLE;
            end
            ST_IDLE: begin
                if (i_valid) begin
                    case (i_command)
                        CMD_LOAD_WEIGHT: n_state = ST_LOAD_W;
                        CMD_LOAD_EDGE:   n_state = ST_EDGE_RD;
                        CMD_SOLVE:       n_state = ST_VCLR;
                        CMD_QUERY:       n_state = ST_QRY_RD;
                        default:         n_state = ST_IDLE;
                    endcase
                end
            end
            ST_LOAD_W:  n_state = ST_IDLE;
            ST_EDGE_RD: n_state = ST_EDGE_WR;
            ST_EDGE_WR: n_state = ST_IDLE;
            ST_QRY_RD:  n_state = ST_QRY_OUT;
            ST_QRY_OUT: begin
                if (w_out_free) n_state = ST_IDLE;
            end
            ST_VCLR: begin
                if (r_idx == w_n - CW'(1)) n_state = ST_START_RD;
            end
            ST_START_RD: n_state = ST_START_CHK;
            ST_START_CHK: begin
                if (w_vi_rd != MARK_NONE) begin
                    n_state = w_last_start ? ST_IDLE : ST_START_RD;
                end else begin
                    n_state = ST_MARK;
                end
            end
            ST_MARK: n_state = ST_NEXT;
            ST_NEXT: n_state = ST_CHECK;
            ST_CHECK: begin
                case (w_vi_rd)
                    MARK_NONE: n_state = ST_MARK;
                    MARK_PATH: n_state = ST_CYC_RD;
                    default:   n_state = ST_SC_RD;
                endcase
            end
            ST_CYC_RD:  n_state = ST_CYC_ACC;
            ST_CYC_ACC: n_state = (w_nxt_x == r_top) ? ST_SAT : ST_CYC_RD;
            ST_SAT:     n_state = ST_PROP_RD;
            ST_SC_RD:   n_state = ST_SC_GET;
            ST_SC_GET:  n_state = ST_PROP_RD;
            ST_PROP_RD: n_state = ST_PROP_WR;
            ST_PROP_WR: begin
                if (w_prop_done) begin
                    n_state = w_last_start ? ST_IDLE : ST_START_RD;
                end else begin
                    n_state = ST_PROP_RD;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    // Memory controls and handshake outputs
    always_comb begin
        o_ready    = (r_state == ST_IDLE);
        w_wt_we    = 1'b0;
        w_wt_waddr = r_node;
        w_wt_wdata = r_weight;
        w_wt_raddr = r_x;
        w_ed_we    = 1'b0;
        w_ed_waddr = r_node;
        w_ed_wdata = {1'b1, r_target, r_flow};
        w_ed_raddr = r_node;
        w_sc_we    = 1'b0;
        w_sc_waddr = w_pa_rd;
        w_sc_wdata = r_score;
        w_sc_raddr = r_node;
        w_vi_we    = 1'b0;
        w_vi_waddr = r_top;
        w_vi_wdata = MARK_PATH;
        w_vi_raddr = r_top;
        w_pa_we    = 1'b0;
        w_pa_waddr = r_plen[PA_W-1:0];
        w_pa_wdata = w_nxt_top;
        w_pa_raddr = r_k[PA_W-1:0];
        case (r_state)
            ST_CLEAR: begin
                w_sc_we    = 1'b1;
                w_sc_waddr = r_idx[NW-1:0];
                w_sc_wdata = '0;
                w_ed_we    = 1'b1;
                w_ed_waddr = r_idx[NW-1:0];
                w_ed_wdata = '0;
            end
            ST_LOAD_W: begin
                w_wt_we    = w_node_ok;
                w_ed_we    = w_node_ok;
                w_ed_wdata = '0;
            end
            ST_EDGE_WR: begin
                w_ed_we = w_edge_take;
            end
            ST_VCLR: begin
                w_vi_we    = 1'b1;
                w_vi_waddr = r_idx[NW-1:0];
                w_vi_wdata = MARK_NONE;
            end
            ST_START_RD: begin
                w_vi_raddr = r_start;
            end
            ST_START_CHK: begin
                w_pa_we    = (w_vi_rd == MARK_NONE);
                w_pa_waddr = '0;
                w_pa_wdata = r_start;
            end
            ST_MARK: begin
                w_vi_we    = 1'b1;
                w_ed_raddr = r_top;
            end
            ST_NEXT: begin
                w_pa_we    = 1'b1;
                w_vi_raddr = w_nxt_top;
            end
            ST_CYC_RD: begin
                w_ed_raddr = r_x;
            end
            ST_SC_RD: begin
                w_sc_raddr = r_top;
            end
            ST_PROP_WR: begin
                w_vi_we    = 1'b1;
                w_vi_waddr = w_pa_rd;
                w_vi_wdata = MARK_DONE;
                w_sc_we    = 1'b1;
            end
            default: begin
            end
        endcase
    end

    // Datapath next values
    always_comb begin
        n_idx       = r_idx;
        n_start     = r_start;
        n_plen      = r_plen;
        n_k         = r_k;
        n_node      = r_node;
        n_target    = r_target;
        n_flow      = r_flow;
        n_weight    = r_weight;
        n_top       = r_top;
        n_x         = r_x;
        n_acc       = r_acc;
        n_score     = r_score;
        n_out_valid = r_out_valid && !i_ready;
        n_out_node  = r_out_node;
        n_out_succ  = r_out_succ;
        n_out_score = r_out_score;
        n_out_max   = r_out_max;
        case (r_state)
            ST_CLEAR: n_idx = r_idx + CW'(1);
            ST_IDLE: begin
                // capture the request
                if (i_valid) begin
                    n_node   = i_node;
                    n_target = i_edge_target;
                    n_flow   = i_edge_flow;
                    n_weight = i_node_weight;
                    n_idx    = '0;
                end
            end
            ST_QRY_OUT: begin
                // load the result register once it is free
                if (w_out_free) begin
                    n_out_valid = 1'b1;
                    n_out_node  = r_node;
                    if (w_node_ok) begin
                        n_out_succ  = w_qry_succ;
                        n_out_score = signed'(w_sc_rd);
                        n_out_max   = signed'(w_sc_rd) > 0;
                    end else begin
                        n_out_succ  = r_node;
                        n_out_score = '0;
                        n_out_max   = 1'b0;
                    end
                end
            end
            ST_VCLR: begin
                n_idx   = r_idx + CW'(1);
                n_start = '0;
            end
            ST_START_CHK: begin
                if (w_vi_rd != MARK_NONE) begin
                    n_start = r_start + NW'(1);
                end else begin
                    n_top  = r_start;
                    n_plen = PL_W'(1);
                end
            end
            ST_NEXT: begin
                n_top  = w_nxt_top;
                n_plen = r_plen + PL_W'(1);
            end
            ST_CHECK: begin
                n_x   = r_top;
                n_acc = '0;
            end
            ST_CYC_ACC: begin
                n_acc = r_acc + w_wt_ext;
                n_x   = w_nxt_x;
            end
            ST_SAT: begin
                // saturate the cycle sum
                if (r_acc > ACC_HI) begin
                    n_score = SCORE_HI;
                end else if (r_acc < ACC_LO) begin
                    n_score = SCORE_LO;
                end else begin
                    n_score = r_acc[SB-1:0];
                end
                n_k = '0;
            end
            ST_SC_GET: begin
                n_score = signed'(w_sc_rd);
                n_k     = '0;
            end
            ST_PROP_WR: begin
                n_k = r_k + PL_W'(1);
                if (w_prop_done) begin
                    n_start = r_start + NW'(1);
                end
            end
            default: begin
            end
        endcase
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= ST_CLEAR;
            r_node_count <= CW'(MAX_NODES);
            r_idx        <= '0;
            r_start      <= '0;
            r_plen       <= '0;
            r_k          <= '0;
            r_out_valid  <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_idx       <= n_idx;
            r_start     <= n_start;
            r_plen      <= n_plen;
            r_k         <= n_k;
            r_out_valid <= n_out_valid;
            if (i_cfg_valid) begin
                r_node_count <= i_cfg_data;
            end
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        r_node      <= n_node;
        r_target    <= n_target;
        r_flow      <= n_flow;
        r_weight    <= n_weight;
        r_top       <= n_top;
        r_x         <= n_x;
        r_acc       <= n_acc;
        r_score     <= n_score;
        r_out_node  <= n_out_node;
        r_out_succ  <= n_out_succ;
        r_out_score <= n_out_score;
        r_out_max   <= n_out_max;
    end

    assign o_cfg_ready    = 1'b1;
    assign o_valid        = r_out_valid;
    assign o_queried_node = r_out_node;
    assign o_successor    = r_out_succ;
    assign o_cycle_score  = r_out_score;
    assign o_max_wins     = r_out_max;

    // Node weights
    scsc_ram #(.WIDTH(WEIGHT_BITS), .DEPTH(MAX_NODES)) u_weight_ram (
        .i_clk   (i_clk),
        .i_we    (w_wt_we),
        .i_waddr (w_wt_waddr),
        .i_wdata (w_wt_wdata),
        .i_raddr (w_wt_raddr),
        .o_rdata (w_wt_rd)
    );

    // Best edge per node: seen flag, successor, flow
    scsc_ram #(.WIDTH(EW), .DEPTH(MAX_NODES)) u_edge_ram (
        .i_clk   (i_clk),
        .i_we    (w_ed_we),
        .i_waddr (w_ed_waddr),
        .i_wdata (w_ed_wdata),
        .i_raddr (w_ed_raddr),
        .o_rdata (w_ed_rd)
    );

    // Scores from the last solve
    scsc_ram #(.WIDTH(SB), .DEPTH(MAX_NODES)) u_score_ram (
        .i_clk   (i_clk),
        .i_we    (w_sc_we),
        .i_waddr (w_sc_waddr),
        .i_wdata (w_sc_wdata),
        .i_raddr (w_sc_raddr),
        .o_rdata (w_sc_rd)
    );

    // Visit marks
    scsc_ram #(.WIDTH(MARK_BITS), .DEPTH(MAX_NODES)) u_visit_ram (
        .i_clk   (i_clk),
        .i_we    (w_vi_we),
        .i_waddr (w_vi_waddr),
        .i_wdata (w_vi_wdata),
        .i_raddr (w_vi_raddr),
        .o_rdata (w_vi_rd)
    );

    // Path stack
    scsc_ram #(.WIDTH(NW), .DEPTH(MAX_NODES + 1)) u_path_ram (
        .i_clk   (i_clk),
        .i_we    (w_pa_we),
        .i_waddr (w_pa_waddr),
        .i_wdata (w_pa_wdata),
        .i_raddr (w_pa_raddr),
        .o_rdata (w_pa_rd)
    );

    // A walk never pushes more than one entry beyond the nodes in use
    a_plen_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_NEXT) |-> (r_plen <= PL_W'(w_n)))
        else $error("path stack grew past the node count");

    // The walk head stays inside the active node range
    a_top_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_CHECK) |-> (CW'(r_top) < w_n))
        else $error("walk head left the active range");

    // The cycle walker stays inside the active node range
    a_x_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_CYC_ACC) |-> (CW'(r_x) < w_n))
        else $error("cycle walker left the active range");

    // The winner flag follows the sign of the reported score
    a_max_sign: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_max_wins == (o_cycle_score > 0)))
        else $error("winner flag disagrees with score sign");

    // A query result is loaded only from the query output state
    a_out_load: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!o_valid ##1 o_valid) |-> $past(r_state == ST_QRY_OUT))
        else $error("result register loaded outside a query");

endmodule

`default_nettype wire

>>> test/tb_strategy_cycle_sign_classifier.sv
// Testbench for the strategy cycle sign classifier: randomized graphs checked against a predictor.
`timescale 1ns / 1ps

module tb_strategy_cycle_sign_classifier;
    import scsc_pkg::*;

    localparam int NODES        = 64;
    localparam int NW           = 6;
    localparam int CW           = 7;
    localparam int FLOW_W       = 32;
    localparam int WEIGHT_W     = 16;
    localparam int DRAIN_CYCLES = 1000;
    localparam int PHASE_ITEMS  = 180;
    localparam int PHASES       = 9;

    typedef struct {
        logic [1:0]                 cmd;
        logic [NW-1:0]              node;
        logic [NW-1:0]              target;
        logic signed [FLOW_W-1:0]   flow;
        logic signed [WEIGHT_W-1:0] weight;
    } t_request;

    typedef struct {
        logic [NW-1:0]                node;
        logic [NW-1:0]                succ;
        logic signed [SCORE_BITS-1:0] score;
        logic                         wins;
    } t_answer;

    // Block ports
    logic                         i_clk = 1'b0;
    logic                         i_rst_n = 1'b0;
    logic                         i_cfg_valid = 1'b0;
    logic [CW-1:0]                i_cfg_data = '0;
    logic                         i_valid = 1'b0;
    logic [1:0]                   i_command = CMD_LOAD_WEIGHT;
    logic [NW-1:0]                i_node = '0;
    logic [NW-1:0]                i_edge_target = '0;
    logic signed [FLOW_W-1:0]     i_edge_flow = '0;
    logic signed [WEIGHT_W-1:0]   i_node_weight = '0;
    logic                         i_ready = 1'b0;
    logic                         o_cfg_ready;
    logic                         o_ready;
    logic                         o_valid;
    logic [NW-1:0]                o_queried_node;
    logic [NW-1:0]                o_successor;
    logic signed [SCORE_BITS-1:0] o_cycle_score;
    logic                         o_max_wins;

    // Stimulus and expectation bookkeeping
    t_request request_queue[$];
    t_answer  expected_answers[$];
    t_request next_req;
    int       pushed_count = 0;
    int       accepted_count = 0;
    int       error_count = 0;
    int       phase_items = 0;
    int       gen_n = NODES;
    int       send_idle_pct = 0;
    int       recv_idle_pct = 0;

    // Predicted block state
    logic [CW-1:0]                count_reg;
    logic signed [WEIGHT_W-1:0]   weight_mem [NODES];
    logic [NW-1:0]                succ_mem   [NODES];
    logic signed [FLOW_W-1:0]     flow_mem   [NODES];
    logic                         has_edge   [NODES];
    logic [MARK_BITS-1:0]         mark       [NODES];
    logic signed [SCORE_BITS-1:0] score_mem  [NODES];

    strategy_cycle_sign_classifier dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_valid    (i_cfg_valid),
        .o_cfg_ready    (o_cfg_ready),
        .i_cfg_data     (i_cfg_data),
        .i_valid        (i_valid),
        .o_ready        (o_ready),
        .i_command      (i_command),
        .i_node         (i_node),
        .i_edge_target  (i_edge_target),
        .i_edge_flow    (i_edge_flow),
        .i_node_weight  (i_node_weight),
        .o_valid        (o_valid),
        .i_ready        (i_ready),
        .o_queried_node (o_queried_node),
        .o_successor    (o_successor),
        .o_cycle_score  (o_cycle_score),
        .o_max_wins     (o_max_wins)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Clamp the node count register to the usable range
    function automatic int live_nodes();
        if (count_reg == 0) return 1;
        if (count_reg > NODES) return NODES;
        return count_reg;
    endfunction

    // Missing or out-of-range successors behave as a self-loop
    function automatic logic [NW-1:0] next_node(input logic [NW-1:0] v, input int n);
        if (!has_edge[v] || succ_mem[v] >= n) return v;
        return succ_mem[v];
    endfunction

    // Walk successor chains and score every node by the cycle it reaches
    function automatic void run_solve();
        int     n;
        int     start;
        int     top;
        int     j;
        int     k;
        int     path_len;
        int     path [0:NODES];
        longint sum;
        n = live_nodes();
        for (k = 0; k < NODES; k++) mark[k] = MARK_NONE;
        for (start = 0; start < n; start++) begin
            if (mark[start] == MARK_NONE) begin
                path[0] = start;
                path_len = 1;
                top = start;
                while (mark[top] == MARK_NONE && path_len <= NODES) begin
                    mark[top] = MARK_PATH;
                    top = next_node(top, n);
                    path[path_len] = top;
                    path_len++;
                end
                // A fresh cycle: sum the weights back around it
                if (mark[top] == MARK_PATH) begin
                    sum = weight_mem[top];
                    j = path_len - 1;
                    while (j > 0) begin
                        j--;
                        if (path[j] == top) break;
                        sum += weight_mem[path[j]];
                    end
                    if (sum > SCORE_MAX) sum = SCORE_MAX;
                    if (sum < SCORE_MIN) sum = SCORE_MIN;
                    score_mem[top] = sum[SCORE_BITS-1:0];
                    mark[top] = MARK_DONE;
                end
                for (k = 0; k < path_len; k++) begin
                    mark[path[k]] = MARK_DONE;
                    score_mem[path[k]] = score_mem[top];
                end
            end
        end
    endfunction

    // Advance the predicted state by one accepted request
    function automatic void apply_request(input t_request req);
        int      n;
        t_answer ans;
        n = live_nodes();
        case (req.cmd)
            CMD_LOAD_WEIGHT: begin
                if (req.node < n) begin
                    weight_mem[req.node] = req.weight;
                    has_edge[req.node] = 1'b0;
                end
            end
            CMD_LOAD_EDGE: begin
                if (req.node < n && (!has_edge[req.node] || req.flow > flow_mem[req.node])) begin
                    has_edge[req.node] = 1'b1;
                    succ_mem[req.node] = req.target;
                    flow_mem[req.node] = req.flow;
                end
            end
            CMD_SOLVE: begin
                run_solve();
            end
            default: begin
                ans.node = req.node;
                if (req.node < n) begin
                    ans.succ  = next_node(req.node, n);
                    ans.score = score_mem[req.node];
                    ans.wins  = (score_mem[req.node] > 0);
                end else begin
                    ans.succ  = req.node;
                    ans.score = '0;
                    ans.wins  = 1'b0;
                end
                expected_answers.insert(expected_answers.size(), ans);
            end
        endcase
    endfunction

    // Compare one result against the oldest expected answer
    function automatic void check_answer();
        t_answer ans;
        if (expected_answers.size() == 0) begin
            error_count++;
            if (error_count <= 10)
                $display("unexpected result: node %0d succ %0d score %0d wins %0b",
                         o_queried_node, o_successor, o_cycle_score, o_max_wins);
            return;
        end
        ans = expected_answers.pop_front();
        if (o_queried_node !== ans.node || o_successor !== ans.succ ||
            o_cycle_score !== ans.score || o_max_wins !== ans.wins) begin
            error_count++;
            if (error_count <= 10)
                $display("mismatch: exp node %0d succ %0d score %0d wins %0b,",
                         ans.node, ans.succ, ans.score, ans.wins,
                         " got node %0d succ %0d score %0d wins %0b",
                         o_queried_node, o_successor, o_cycle_score, o_max_wins);
        end
    endfunction

    // Request driver: hold until taken, then offer the next one or idle
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_valid <= 1'b0;
        end else if (!(i_valid && !o_ready)) begin
            if (i_valid) begin
                next_req.cmd    = i_command;
                next_req.node   = i_node;
                next_req.target = i_edge_target;
                next_req.flow   = i_edge_flow;
                next_req.weight = i_node_weight;
                apply_request(next_req);
                accepted_count++;
            end
            if (request_queue.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
                next_req = request_queue.pop_front();
                i_valid       <= 1'b1;
                i_command     <= next_req.cmd;
                i_node        <= next_req.node;
                i_edge_target <= next_req.target;
                i_edge_flow   <= next_req.flow;
                i_node_weight <= next_req.weight;
            end else begin
                i_valid <= 1'b0;
            end
        end
    end

    // Result monitor with random back-pressure
    always @(posedge i_clk) begin
        if (i_rst_n && o_valid === 1'b1 && i_ready)
            check_answer();
        i_ready <= ($urandom_range(99) >= recv_idle_pct);
    end

    function automatic logic signed [FLOW_W-1:0] rand_flow();
        case ($urandom_range(7))
            0: return 32'sh7FFFFFFF;
            1: return 32'sh80000000;
            2, 3: return 32'($urandom_range(8)) - 32'd4;
            default: return $urandom;
        endcase
    endfunction

    function automatic logic signed [WEIGHT_W-1:0] rand_weight();
        if ($urandom_range(4) == 0)
            return $urandom_range(1) ? 16'sh7FFF : 16'sh8000;
        return $urandom;
    endfunction

    // Mostly in-range nodes, sometimes any index
    function automatic logic [NW-1:0] pick_node();
        if ($urandom_range(9) == 0) return $urandom_range(NODES - 1);
        return $urandom_range(gen_n - 1);
    endfunction

    function automatic void push_request(input logic [1:0] cmd, input logic [NW-1:0] node,
                                         input logic [NW-1:0] target,
                                         input logic signed [FLOW_W-1:0] flow,
                                         input logic signed [WEIGHT_W-1:0] weight);
        t_request req;
        req.cmd    = cmd;
        req.node   = node;
        req.target = target;
        req.flow   = flow;
        req.weight = weight;
        request_queue.insert(request_queue.size(), req);
        pushed_count++;
        if (cmd == CMD_SOLVE || cmd == CMD_QUERY || node < gen_n) phase_items++;
    endfunction

    function automatic void push_query(input logic [NW-1:0] node);
        push_request(CMD_QUERY, node, $urandom, $urandom, $urandom);
    endfunction

    function automatic void push_solve();
        push_request(CMD_SOLVE, $urandom, $urandom, $urandom, $urandom);
    endfunction

    function automatic void push_edge(input logic [NW-1:0] node, input logic [NW-1:0] target,
                                      input logic signed [FLOW_W-1:0] flow);
        push_request(CMD_LOAD_EDGE, node, target, flow, $urandom);
    endfunction

    function automatic void push_weight(input logic [NW-1:0] node,
                                        input logic signed [WEIGHT_W-1:0] weight);
        push_request(CMD_LOAD_WEIGHT, node, $urandom, $urandom, weight);
    endfunction

    // Ties, extreme flows, plain self-loop, tails into a cycle, zero-sum cycle
    function automatic void push_directed();
        push_edge(0, 1, 100);
        push_edge(0, 2, 100);
        push_edge(0, 3, 32'sh80000000);
        push_edge(1, 0, 32'sh7FFFFFFF);
        push_edge(3, 63, 0);
        push_edge(63, 3, -1);
        push_edge(4, 4, 7);
        push_edge(5, 0, -5);
        push_query(0);
        push_solve();
        push_query(0);
        push_query(1);
        push_query(2);
        push_query(3);
        push_query(4);
        push_query(5);
        push_query(63);
        push_weight(0, 0);
        push_weight(1, 0);
        push_edge(0, 1, 32'sh80000000);
        push_edge(1, 0, 32'sh80000000);
        push_weight(2, 16'sh8000);
        push_solve();
        push_query(0);
        push_query(5);
        push_query(2);
    endfunction

    // Random graph fragments, whole rings and stray requests
    function automatic void push_random(input int target_items);
        int          sel;
        int          k;
        int          e;
        int          v;
        logic signed [WEIGHT_W-1:0] w;
        while (phase_items < target_items) begin
            sel = $urandom_range(99);
            if (sel < 60) begin
                for (k = $urandom_range(1, 6); k > 0; k--) begin
                    v = pick_node();
                    push_weight(v, rand_weight());
                    for (e = $urandom_range(3); e > 0; e--)
                        push_edge(v, ($urandom_range(6) == 0) ? $urandom_range(NODES - 1)
                                                              : $urandom_range(gen_n - 1),
                                  rand_flow());
                end
                if ($urandom_range(9) < 7) push_solve();
                for (k = $urandom_range(1, 4); k > 0; k--) push_query(pick_node());
            end else if (sel < 63) begin
                case ($urandom_range(2))
                    0: w = 16'sh7FFF;
                    1: w = 16'sh8000;
                    default: w = $urandom;
                endcase
                for (v = 0; v < gen_n; v++) begin
                    push_weight(v, w);
                    push_edge(v, (v + 1) % gen_n, rand_flow());
                end
                push_solve();
                for (k = 0; k < 3; k++) push_query(pick_node());
            end else begin
                push_request($urandom, $urandom, $urandom, $urandom, $urandom);
            end
        end
    endfunction

    // Wait until every request is taken and every answer has come back
    task automatic wait_drained();
        do @(posedge i_clk);
        while (accepted_count != pushed_count || expected_answers.size() != 0);
    endtask

    task automatic settle();
        wait_drained();
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_node_count(input logic [CW-1:0] value);
        @(posedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= value;
        do @(posedge i_clk);
        while (o_cfg_ready !== 1'b1);
        count_reg = value;
        i_cfg_valid <= 1'b0;
    endtask

    function automatic logic [CW-1:0] count_for_phase(input int phase);
        case (phase)
            0: return 7'd64;
            1: return 7'd0;
            2: return 7'd127;
            3: return 7'd3;
            4: return 7'd64;
            5: return 7'd1;
            6: return 7'd65;
            7: return 7'd20;
            default: return $urandom_range(2, 63);
        endcase
    endfunction

    initial begin
        int phase;
        int k;
        count_reg = 7'd64;
        for (k = 0; k < NODES; k++) begin
            has_edge[k]  = 1'b0;
            mark[k]      = MARK_NONE;
            score_mem[k] = '0;
        end
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;

        for (phase = 0; phase < PHASES; phase++) begin
            // Receiver-heavy idling, then sender-heavy, then none
            if (phase < 3) begin
                send_idle_pct = 18;
                recv_idle_pct = 59;
            end else if (phase < 6) begin
                send_idle_pct = 59;
                recv_idle_pct = 18;
            end else begin
                send_idle_pct = 0;
                recv_idle_pct = 0;
            end
            if (phase != 0) settle();
            write_node_count(count_for_phase(phase));
            gen_n = live_nodes();
            phase_items = 0;
            if (phase == 0) begin
                // Give every node a weight before any solve reads one
                for (k = 0; k < NODES; k++) push_weight(k, rand_weight());
                push_directed();
            end
            push_random(PHASE_ITEMS / 2);
            if (phase == 3) wait_drained();
            push_random(PHASE_ITEMS);
        end
        settle();

        if (error_count == 0 && expected_answers.size() == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

    // Run limit
    initial begin
        #100_000_000;
        $display("DONE: errors detected");
        $finish;
    end

endmodule
